[rtl/core/htfa_pkg.sv]
package htfa_pkg;

    // Field and code widths of one sensor frame and of one result item.
    localparam int CODE_W   = 20;
    localparam int BYTE_W   = 8;
    localparam int NIBBLE_W = 4;
    localparam int TEMP_W   = 15;
    localparam int HUM_W    = 14;

    // Scale factors: full code range maps to 200.00 degC span and 100.00 %RH.
    localparam int TSPAN_W = 15;
    localparam int HSPAN_W = 14;
    localparam int TPROD_W = CODE_W + TSPAN_W;
    localparam int HPROD_W = CODE_W + HSPAN_W;
    localparam int OFFS_W  = TEMP_W + 1;

    localparam logic [TSPAN_W-1:0] TEMP_SPAN = 15'd20000;
    localparam logic [HSPAN_W-1:0] HUM_SPAN  = 14'd10000;
    localparam logic signed [OFFS_W-1:0] TEMP_OFFSET = 16'sd5000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // store the accepted item in the rings
        logic acc_step;  // add one ring entry to the running sums
        logic div_load;  // load the sums into the divider
        logic div_step;  // one restoring division step
        logic scale;     // multiply the averages by the scale factors
        logic load_out;  // move the scaled result to the output register
    } htfa_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sum_last;  // the current accumulate step reads the last held entry
        logic div_last;  // the current division step is the final one
        logic out_free;  // the output register can take a new result
    } htfa_sts_t;

endpackage

[rtl/core/htfa_ctrl.sv]
module htfa_ctrl
    import htfa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  htfa_sts_t sts,
    output htfa_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SUM   = 3'd1;
    localparam logic [2:0] ST_DLOAD = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_SCALE = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // An item is taken only while the controller is idle.
    assign in_stall = (state_reg != ST_IDLE);

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SUM;
                end
            end
            ST_SUM:
            begin
                cmd.acc_step = 1'b1;
                if (sts.sum_last)
                begin
                    state_next = ST_DLOAD;
                end
            end
            ST_DLOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A result is handed over only when the output register has room.
    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("result loaded while output register is occupied");

    // After a capture the block runs through the accumulate phase.
    a_capture_to_sum: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == ST_SUM))
        else $error("capture not followed by accumulation");

    // The controller returns to idle exactly when a result is loaded.
    a_out_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) && sts.out_free |=> (state_reg == ST_IDLE))
        else $error("controller did not return to idle after loading a result");

endmodule

[rtl/core/htfa_dp.sv]
module htfa_dp
    import htfa_pkg::*;
#(
    parameter int DEPTH = 3
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  htfa_cmd_t                cmd,
    output htfa_sts_t                sts,
    input  logic [BYTE_W-1:0]        hum_high_byte,
    input  logic [BYTE_W-1:0]        hum_mid_byte,
    input  logic [BYTE_W-1:0]        shared_byte,
    input  logic [BYTE_W-1:0]        temp_mid_byte,
    input  logic [BYTE_W-1:0]        temp_low_byte,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [TEMP_W-1:0] temperature_centi,
    output logic [HUM_W-1:0]         humidity_centi
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W  = CODE_W + CNT_W;
    localparam int STEP_W = $clog2(SUM_W);

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

    logic [CODE_W-1:0] temp_ring_reg [DEPTH];
    logic [CODE_W-1:0] hum_ring_reg  [DEPTH];
    logic [SLOT_W-1:0] write_slot_reg;
    logic [CNT_W-1:0]  fill_reg;
    logic [SLOT_W-1:0] rd_idx_reg;
    logic [SUM_W-1:0]  t_sum_reg;
    logic [SUM_W-1:0]  h_sum_reg;
    logic [SUM_W-1:0]  t_quo_reg;
    logic [SUM_W-1:0]  h_quo_reg;
    logic [CNT_W-1:0]  t_rem_reg;
    logic [CNT_W-1:0]  h_rem_reg;
    logic [STEP_W-1:0] step_reg;
    logic [TPROD_W-1:0] t_prod_reg;
    logic [HPROD_W-1:0] h_prod_reg;
    logic               out_valid_reg;
    logic signed [TEMP_W-1:0] temperature_centi_reg;
    logic [HUM_W-1:0]         humidity_centi_reg;

    logic [CODE_W-1:0] hum_code;
    logic [CODE_W-1:0] temp_code;
    logic [CNT_W:0]    t_shift;
    logic [CNT_W:0]    h_shift;
    logic [CNT_W+1:0]  t_diff;
    logic [CNT_W+1:0]  h_diff;
    logic              t_ge;
    logic              h_ge;
    logic signed [OFFS_W-1:0] t_scaled;

    // Frame decode into the two 20-bit codes.
    assign hum_code  = {hum_high_byte, hum_mid_byte, shared_byte[BYTE_W-1:NIBBLE_W]};
    assign temp_code = {shared_byte[NIBBLE_W-1:0], temp_mid_byte, temp_low_byte};

    // Ring storage: entries are only read after they have been written.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            temp_ring_reg[write_slot_reg] <= temp_code;
            hum_ring_reg[write_slot_reg]  <= hum_code;
        end
    end

    // Write pointer and fill count, saturating at the ring depth.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_slot_reg <= '0;
            fill_reg       <= '0;
        end
        else if (cmd.capture)
        begin
            write_slot_reg <= (write_slot_reg == LAST_SLOT) ? '0 : write_slot_reg + 1'b1;
            if (fill_reg != FULL_CNT)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    // Accumulate one held entry per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rd_idx_reg <= '0;
            t_sum_reg  <= '0;
            h_sum_reg  <= '0;
        end
        else if (cmd.acc_step)
        begin
            rd_idx_reg <= rd_idx_reg + 1'b1;
            t_sum_reg  <= t_sum_reg + SUM_W'(temp_ring_reg[rd_idx_reg]);
            h_sum_reg  <= h_sum_reg + SUM_W'(hum_ring_reg[rd_idx_reg]);
        end
    end

    assign sts.sum_last = (CNT_W'(rd_idx_reg) == fill_reg - 1'b1);

    // Restoring division of both sums by the fill count, one bit per cycle.
    assign t_shift = {t_rem_reg, t_quo_reg[SUM_W-1]};
    assign h_shift = {h_rem_reg, h_quo_reg[SUM_W-1]};
    assign t_diff  = {1'b0, t_shift} - {2'b00, fill_reg};
    assign h_diff  = {1'b0, h_shift} - {2'b00, fill_reg};
    assign t_ge    = !t_diff[CNT_W+1];
    assign h_ge    = !h_diff[CNT_W+1];

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            t_quo_reg <= t_sum_reg;
            h_quo_reg <= h_sum_reg;
            t_rem_reg <= '0;
            h_rem_reg <= '0;
            step_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            t_quo_reg <= {t_quo_reg[SUM_W-2:0], t_ge};
            h_quo_reg <= {h_quo_reg[SUM_W-2:0], h_ge};
            t_rem_reg <= t_ge ? t_diff[CNT_W-1:0] : t_shift[CNT_W-1:0];
            h_rem_reg <= h_ge ? h_diff[CNT_W-1:0] : h_shift[CNT_W-1:0];
            step_reg  <= step_reg + 1'b1;
        end
    end

    assign sts.div_last = (step_reg == LAST_STEP);

    // Scale the averages; the quotient always fits in a code.
    always_ff @(posedge clk)
    begin
        if (cmd.scale)
        begin
            t_prod_reg <= TPROD_W'(t_quo_reg[CODE_W-1:0]) * TPROD_W'(TEMP_SPAN);
            h_prod_reg <= HPROD_W'(h_quo_reg[CODE_W-1:0]) * HPROD_W'(HUM_SPAN);
        end
    end

    assign t_scaled = $signed({1'b0, t_prod_reg[TPROD_W-1:CODE_W]}) - TEMP_OFFSET;

    // Output register: holds a result until it is taken.
    assign sts.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            temperature_centi_reg <= t_scaled[TEMP_W-1:0];
            humidity_centi_reg    <= h_prod_reg[HPROD_W-1:CODE_W];
        end
    end

    assign out_valid         = out_valid_reg;
    assign temperature_centi = temperature_centi_reg;
    assign humidity_centi    = humidity_centi_reg;

    // The fill count never passes the ring depth.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FULL_CNT)
        else $error("fill count above ring depth");

    // The write pointer stays inside the ring.
    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        write_slot_reg <= LAST_SLOT)
        else $error("write pointer outside ring");

    // The division remainders stay below the divisor.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.div_step) |-> (t_rem_reg < fill_reg) && (h_rem_reg < fill_reg))
        else $error("division remainder not below the sample count");

endmodule

[rtl/core/humidity_temp_frame_averager.sv]
// From item accept to result valid the item passes the ring capture, the ring sum over the N
// held samples (1 to DEPTH), the divider load, the division, the scaling and the output load.
// No new item is taken until the previous result is loaded into the output register; the
// one-bit-per-cycle restoring divider and the one-entry-per-cycle ring sum set the pace.
// A result waiting in the output register does not block the next item until its final load.
// Reset (rst_n low, asynchronous): ring empty, write pointer zero, no result pending.
module humidity_temp_frame_averager
    import htfa_pkg::*;
#(
    parameter int DEPTH = 3
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [BYTE_W-1:0]        hum_high_byte,
    input  logic [BYTE_W-1:0]        hum_mid_byte,
    input  logic [BYTE_W-1:0]        shared_byte,
    input  logic [BYTE_W-1:0]        temp_mid_byte,
    input  logic [BYTE_W-1:0]        temp_low_byte,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [TEMP_W-1:0] temperature_centi,
    output logic [HUM_W-1:0]         humidity_centi
);

    htfa_cmd_t cmd;
    htfa_sts_t sts;

    // Sequencer.
    htfa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Ring, sum, divider, scaling and output register.
    htfa_dp #(
        .DEPTH (DEPTH)
    ) u_dp
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .hum_high_byte     (hum_high_byte),
        .hum_mid_byte      (hum_mid_byte),
        .shared_byte       (shared_byte),
        .temp_mid_byte     (temp_mid_byte),
        .temp_low_byte     (temp_low_byte),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .temperature_centi (temperature_centi),
        .humidity_centi    (humidity_centi)
    );

endmodule

[tb/humidity_temp_frame_averager_tb.sv]
`timescale 1ns / 1ps

module humidity_temp_frame_averager_tb
    import htfa_pkg::*;
();

    localparam int HIST_DEPTH   = 3;
    localparam int RANDOM_ITEMS = 930;
    localparam int QUIET_TAIL   = 100;
    localparam int LONG_HOLD    = 90;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 10;

    // One frame as the sensor sends it, with an optional hand-computed reading.
    typedef struct {
        logic [BYTE_W-1:0]        hum_hi;
        logic [BYTE_W-1:0]        hum_mid;
        logic [BYTE_W-1:0]        shared;
        logic [BYTE_W-1:0]        temp_mid;
        logic [BYTE_W-1:0]        temp_lo;
        bit                       known;
        logic signed [TEMP_W-1:0] temp_known;
        logic [HUM_W-1:0]         hum_known;
    } frame_row_t;

    // One averaged reading as the block reports it.
    typedef struct {
        logic signed [TEMP_W-1:0] temp;
        logic [HUM_W-1:0]         hum;
    } reading_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [BYTE_W-1:0]        hum_high_byte;
    logic [BYTE_W-1:0]        hum_mid_byte;
    logic [BYTE_W-1:0]        shared_byte;
    logic [BYTE_W-1:0]        temp_mid_byte;
    logic [BYTE_W-1:0]        temp_low_byte;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [TEMP_W-1:0] temperature_centi;
    logic [HUM_W-1:0]         humidity_centi;

    // Sample history kept by the testbench, mirroring the block's rings.
    logic [CODE_W-1:0] temp_hist [HIST_DEPTH];
    logic [CODE_W-1:0] hum_hist [HIST_DEPTH];
    int                hist_slot = 0;
    int                hist_count = 0;

    frame_row_t frame_table[$];
    reading_t   pending_readings[$];
    int         mismatch_count = 0;
    bit         idle_on = 1'b1;
    bit         quiet_tail = 1'b0;
    bit         hold_request = 1'b0;

    humidity_temp_frame_averager #(
        .DEPTH(HIST_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .hum_high_byte(hum_high_byte),
        .hum_mid_byte(hum_mid_byte),
        .shared_byte(shared_byte),
        .temp_mid_byte(temp_mid_byte),
        .temp_low_byte(temp_low_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .temperature_centi(temperature_centi),
        .humidity_centi(humidity_centi)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Store one frame in the history and return the mean reading over what is held.
    function automatic reading_t average_frame(input frame_row_t row);
        logic [CODE_W-1:0] hum_code;
        logic [CODE_W-1:0] temp_code;
        longint unsigned   temp_total;
        longint unsigned   hum_total;
        longint unsigned   temp_avg;
        longint unsigned   hum_avg;
        longint            temp_scaled;
        longint unsigned   hum_scaled;
        reading_t          r;
        hum_code  = {row.hum_hi, row.hum_mid, row.shared[7:4]};
        temp_code = {row.shared[3:0], row.temp_mid, row.temp_lo};
        temp_hist[hist_slot] = temp_code;
        hum_hist[hist_slot]  = hum_code;
        hist_slot = (hist_slot + 1 >= HIST_DEPTH) ? 0 : hist_slot + 1;
        if (hist_count < HIST_DEPTH)
            hist_count++;
        temp_total = 0;
        hum_total  = 0;
        for (int i = 0; i < hist_count; i++)
        begin
            temp_total += temp_hist[i];
            hum_total  += hum_hist[i];
        end
        temp_avg = temp_total / hist_count;
        hum_avg  = hum_total / hist_count;
        // Scale to hundredths; both products truncate toward zero.
        temp_scaled = longint'((temp_avg * TEMP_SPAN) >> CODE_W) - longint'(TEMP_OFFSET);
        hum_scaled  = (hum_avg * HUM_SPAN) >> CODE_W;
        r.temp = temp_scaled[TEMP_W-1:0];
        r.hum  = hum_scaled[HUM_W-1:0];
        return r;
    endfunction

    // Append one row to the directed table.
    task automatic add_row(input logic [BYTE_W-1:0] b1, input logic [BYTE_W-1:0] b2,
                           input logic [BYTE_W-1:0] b3, input logic [BYTE_W-1:0] b4,
                           input logic [BYTE_W-1:0] b5, input bit known,
                           input int temp_known, input int hum_known);
        frame_row_t row;
        row.hum_hi     = b1;
        row.hum_mid    = b2;
        row.shared     = b3;
        row.temp_mid   = b4;
        row.temp_lo    = b5;
        row.known      = known;
        row.temp_known = TEMP_W'(temp_known);
        row.hum_known  = HUM_W'(hum_known);
        frame_table.push_back(row);
    endtask

    // Random byte that favors the two extremes.
    function automatic logic [BYTE_W-1:0] pick_byte();
        int roll;
        roll = $urandom_range(0, 7);
        if (roll == 0)
            return '0;
        else if (roll == 1)
            return '1;
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    function automatic frame_row_t random_frame();
        frame_row_t row;
        row.hum_hi     = pick_byte();
        row.hum_mid    = pick_byte();
        row.shared     = pick_byte();
        row.temp_mid   = pick_byte();
        row.temp_lo    = pick_byte();
        row.known      = 1'b0;
        row.temp_known = '0;
        row.hum_known  = '0;
        return row;
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
    endfunction

    // Offer one frame and keep it steady until the block takes it.
    task automatic offer_frame(input frame_row_t row);
        reading_t predicted;
        @(negedge clk);
        hum_high_byte <= row.hum_hi;
        hum_mid_byte  <= row.hum_mid;
        shared_byte   <= row.shared;
        temp_mid_byte <= row.temp_mid;
        temp_low_byte <= row.temp_lo;
        in_valid      <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        predicted = average_frame(row);
        if (row.known)
        begin
            predicted.temp = row.temp_known;
            predicted.hum  = row.hum_known;
        end
        pending_readings.push_back(predicted);
    endtask

    // Drop valid for a number of cycles.
    task automatic sender_gap(input int cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Occasionally pause the sender for a short random burst.
    task automatic maybe_gap();
        if (idle_on && !quiet_tail && $urandom_range(0, 3) == 0)
            sender_gap($urandom_range(1, 4));
    endtask

    task automatic wait_drained();
        while (pending_readings.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_stall = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (idle_on && !quiet_tail && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 3);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Compare each delivered reading with the oldest prediction.
    always @(posedge clk)
    begin : check_readings
        reading_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_readings.size() == 0)
                note_mismatch($sformatf("unexpected reading temp=%0d hum=%0d",
                                        temperature_centi, humidity_centi));
            else
            begin
                want = pending_readings.pop_front();
                if (temperature_centi !== want.temp || humidity_centi !== want.hum)
                    note_mismatch($sformatf("expected temp=%0d hum=%0d, got temp=%0d hum=%0d",
                                            want.temp, want.hum, temperature_centi,
                                            humidity_centi));
            end
        end
    end

    // Stimulus: directed frames, then random frames, then drain and report.
    initial
    begin
        frame_row_t row;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        hum_high_byte = '0;
        hum_mid_byte  = '0;
        shared_byte   = '0;
        temp_mid_byte = '0;
        temp_low_byte = '0;

        // Zero frame into an empty ring, then fill with full-scale codes.
        add_row(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, -5000, 0);
        add_row(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 0, 0);
        add_row(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 0, 0);
        add_row(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 14999, 9999);
        // Split the shared byte: humidity-only and temperature-only extremes.
        add_row(8'hFF, 8'hFF, 8'hF0, 8'h00, 8'h00, 1'b0, 0, 0);
        add_row(8'h00, 8'h00, 8'h0F, 8'hFF, 8'hFF, 1'b0, 0, 0);
        add_row(8'hFF, 8'hFF, 8'hF0, 8'h00, 8'h00, 1'b0, 0, 0);
        add_row(8'h00, 8'h00, 8'h0F, 8'hFF, 8'hFF, 1'b0, 0, 0);
        add_row(8'h00, 8'h00, 8'h0F, 8'hFF, 8'hFF, 1'b0, 0, 0);
        add_row(8'h00, 8'h00, 8'h0F, 8'hFF, 8'hFF, 1'b1, 14999, 0);
        // Wrap around with zero frames until the ring holds only zeros.
        add_row(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 0, 0);
        add_row(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 0, 0);
        add_row(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, -5000, 0);
        // Mid-scale and alternating bit patterns.
        add_row(8'h80, 8'h00, 8'h08, 8'h00, 8'h00, 1'b0, 0, 0);
        add_row(8'hAA, 8'h55, 8'hA5, 8'h5A, 8'hA5, 1'b0, 0, 0);
        add_row(8'h55, 8'hAA, 8'h5A, 8'hA5, 8'h5A, 1'b0, 0, 0);
        add_row(8'h01, 8'h02, 8'h34, 8'h56, 8'h78, 1'b0, 0, 0);
        add_row(8'h7F, 8'hFF, 8'hF7, 8'hFF, 8'hFF, 1'b0, 0, 0);
        add_row(8'h00, 8'h00, 8'h1E, 8'h00, 8'h01, 1'b0, 0, 0);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, back to back.
        foreach (frame_table[i])
            offer_frame(frame_table[i]);
        sender_gap(1);
        wait_drained();

        // Random part, in segments with and without idling.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
                idle_on = ($urandom_range(0, 2) != 0);
            if (n == RANDOM_ITEMS - QUIET_TAIL)
                quiet_tail = 1'b1;
            if (n == 200)
            begin
                idle_on = 1'b0;
                hold_request = 1'b1;
            end
            if (n == 500)
            begin
                sender_gap(1);
                wait_drained();
            end
            row = random_frame();
            offer_frame(row);
            maybe_gap();
        end
        sender_gap(1);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_readings.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[sim.f]
rtl/core/htfa_pkg.sv
rtl/core/htfa_ctrl.sv
rtl/core/htfa_dp.sv
rtl/core/humidity_temp_frame_averager.sv
tb/humidity_temp_frame_averager_tb.sv
